/* src/frpd_pkg.sv */
// Package for the floating-point row predictor decoder.
// Holds register codes, field widths, reset values and the configuration struct.
// No dependencies.
package frpd_pkg;

    // Field widths fixed by the stream and register formats.
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 14;
    localparam int MODE_W   = 2;
    localparam int ROWV_W   = 15;
    localparam int STRIDE_W = 3;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = 2;

    // Number of byte planes held in the store; the fourth completes the word.
    localparam int PLANES_STORED = 3;

    // Register indexes on the configuration port.
    localparam logic [REGIDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_ROW_LEN = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_STRIDE  = 2'd2;

    // Reset values of the registers.
    localparam logic [MODE_W-1:0]   MODE_RESET   = 2'd2;
    localparam logic [ROWV_W-1:0]   ROWV_RESET   = 15'd1024;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 3'd3;

    // Mode bits: bit 1 selects the predictor, bit 0 big-endian packing.
    localparam int MODE_PRED_BIT = 1;
    localparam int MODE_BE_BIT   = 0;

    // Register contents and the row restart strobe handed to the datapath.
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ROWV_W-1:0]   row_len;
        logic [STRIDE_W-1:0] stride;
        logic                restart;
    } t_cfg;

endpackage

/* src/frpd_ram.sv */
// Generic single-port-write, single-port-read RAM with byte-lane write enables.
// Read data is registered. Uses no package.
module frpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                                i_clk,
    input  logic [WIDTH/8-1:0]                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    localparam int LANES = WIDTH / 8;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Byte-lane writes.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_we[l]) begin
                r_mem[i_waddr][l*8 +: 8] <= i_wdata[l*8 +: 8];
            end
        end
    end

    // Registered read, held while no read is requested.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/frpd_cfg.sv */
// Configuration registers of the row predictor decoder behind an APB-style port.
// Depends on frpd_pkg for register codes, widths and the t_cfg struct.
module frpd_cfg
    import frpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [MODE_W-1:0]   r_mode;
    logic [ROWV_W-1:0]   r_row_len;
    logic [STRIDE_W-1:0] r_stride;

    logic [REGIDX_W-1:0] w_idx;
    logic                w_wr;
    logic                w_hit;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // A write to any defined register restarts the row.
    always_comb begin
        case (w_idx)
            REG_MODE:    w_hit = 1'b1;
            REG_ROW_LEN: w_hit = 1'b1;
            REG_STRIDE:  w_hit = 1'b1;
            default:     w_hit = 1'b0;
        endcase
    end

    // Register writes during the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RESET;
            r_row_len <= ROWV_RESET;
            r_stride  <= STRIDE_RESET;
        end else begin
            if (w_wr) begin
                case (w_idx)
                    REG_MODE:    r_mode    <= pwdata[MODE_W-1:0];
                    REG_ROW_LEN: r_row_len <= pwdata[ROWV_W-1:0];
                    REG_STRIDE:  r_stride  <= pwdata[STRIDE_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // Read-back of the register contents.
    always_comb begin
        case (w_idx)
            REG_MODE:    prdata = PDATA_W'(r_mode);
            REG_ROW_LEN: prdata = PDATA_W'(r_row_len);
            REG_STRIDE:  prdata = PDATA_W'(r_stride);
            default:     prdata = '0;
        endcase
    end

    // The restart strobe acts at the same edge as the register write.
    assign o_cfg = '{mode: r_mode, row_len: r_row_len, stride: r_stride,
                     restart: w_wr && w_hit};

endmodule

/* src/float_row_predictor_decoder.sv */
// Top level of the floating-point row predictor decoder: row sequencing, predictor
// add, byte-plane store and output pipeline. Depends on frpd_pkg, frpd_cfg, frpd_ram.
//
//  Channel      | Direction | Transfer when            | Contents
//  -------------+-----------+--------------------------+--------------------------------
//  s_axis       | in        | tvalid & tready          | tdata[7:0] in_byte
//  m_axis       | out       | tvalid & tready          | tdata value_bits, value_index;
//               |           |                          | tlast row_last
//  APB (p*)     | in        | psel & penable & pwrite  | mode, row_values, stride
//
// One byte is taken per cycle while s_axis_tready is high; a result passes from the byte that
// completes it through the middle stage (beside the store read), then the output register.
// The byte-plane store has one write and one read port; in predictor mode each byte costs
// one store access, so the rate is one byte per cycle in every mode, output stalls apart.
// Reset is synchronous and clears the row position, predictor history and pipeline;
// the store needs no clearing pass. A stalled output holds one result in the output
// register and one behind it before s_axis_tready falls.
module float_row_predictor_decoder
    import frpd_pkg::*;
#(
    parameter int MAX_ROW_LEN = 16384,
    parameter int MAX_STRIDE  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input byte stream.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
    // Output sample stream.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [47:0]        m_axis_tdata,   // [31:0] value_bits, [45:32] value_index, zeros
    output logic               m_axis_tlast,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int OW  = MAX_ROW_LEN > 1 ? $clog2(MAX_ROW_LEN) : 1;
    localparam int PW  = $clog2(4 * MAX_ROW_LEN);
    localparam int VW  = $clog2(MAX_ROW_LEN + 1);
    localparam int SW  = $clog2(MAX_STRIDE + 1);
    localparam int RIW = MAX_STRIDE > 1 ? $clog2(MAX_STRIDE) : 1;
    localparam int SW_STORE = PLANES_STORED * BYTE_W;

    t_cfg w_cfg;

    // Row sequencing state.
    logic [PW-1:0]     r_pos,     n_pos;
    logic [1:0]        r_plane,   n_plane;
    logic [OW-1:0]     r_off,     n_off;
    logic [BYTE_W-1:0] r_recent [MAX_STRIDE];
    logic [23:0]       r_partial, n_partial;

    // Stage between the store read and the output register.
    logic               r_s1_valid;
    logic               r_s1_pred;
    logic [WORD_W-1:0]  r_s1_word;
    logic [INDEX_W-1:0] r_s1_index;
    logic               r_s1_last;

    // Output register.
    logic               r_o_valid;
    logic [WORD_W-1:0]  r_o_word;
    logic [INDEX_W-1:0] r_o_index;
    logic               r_o_last;

    logic [VW-1:0]      w_vals;
    logic [SW-1:0]      w_st;
    logic [RIW-1:0]     w_tap;
    logic               w_pred;
    logic               w_be;
    logic               w_off_last;
    logic               w_acc;
    logic               w_s1_move;
    logic [BYTE_W-1:0]  w_in;
    logic [BYTE_W-1:0]  w_r;
    logic               w_emit;
    logic [WORD_W-1:0]  w_word;
    logic [INDEX_W-1:0] w_index;
    logic [31:0]        w_wordpos;
    logic [PLANES_STORED-1:0] w_we;
    logic               w_re;
    logic [SW_STORE-1:0] w_rdata;
    logic [WORD_W-1:0]  w_s1_out;

    frpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Effective row length and stride, clamped into their legal ranges.
    always_comb begin
        if (w_cfg.row_len == '0) begin
            w_vals = VW'(1);
        end else if (32'(w_cfg.row_len) > MAX_ROW_LEN) begin
            w_vals = VW'(MAX_ROW_LEN);
        end else begin
            w_vals = VW'(w_cfg.row_len);
        end
        if (w_cfg.stride == '0) begin
            w_st = SW'(1);
        end else if (32'(w_cfg.stride) > MAX_STRIDE) begin
            w_st = SW'(MAX_STRIDE);
        end else begin
            w_st = SW'(w_cfg.stride);
        end
    end

    assign w_tap      = RIW'(32'(w_st) - 32'd1);
    assign w_pred     = w_cfg.mode[MODE_PRED_BIT];
    assign w_be       = w_cfg.mode[MODE_BE_BIT];
    assign w_off_last = (32'(r_off) + 32'd1) == 32'(w_vals);
    assign w_in       = s_axis_tdata;

    // Handshake: the middle stage moves on when the output register frees up.
    assign w_s1_move     = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_move;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // Predictor reconstruction and word assembly for the byte being taken.
    always_comb begin
        w_wordpos = 32'(r_pos) >> 2;
        w_r       = w_in;
        w_emit    = 1'b0;
        w_word    = '0;
        w_index   = '0;
        w_we      = '0;
        n_partial = r_partial;
        if (w_pred) begin
            if (32'(r_pos) >= 32'(w_st)) begin
                w_r = w_in + r_recent[w_tap];
            end
            n_partial = '0;
            if (r_plane == 2'd3) begin
                w_emit  = 1'b1;
                w_word  = {24'd0, w_r};
                w_index = INDEX_W'(r_off);
            end else begin
                w_we[r_plane] = 1'b1;
            end
        end else if (r_pos[1:0] == 2'd3) begin
            w_emit    = 1'b1;
            w_index   = w_wordpos[INDEX_W-1:0];
            n_partial = '0;
            if (w_be) begin
                w_word = {r_partial, w_in};
            end else begin
                w_word = {w_in, r_partial[7:0], r_partial[15:8], r_partial[23:16]};
            end
        end else begin
            n_partial = {r_partial[15:0], w_in};
        end
    end

    assign w_re = w_acc && w_pred && (r_plane == 2'd3);

    // Row position, plane and offset counters; the last byte wraps all three.
    always_comb begin
        n_pos   = r_pos + PW'(1);
        n_plane = r_plane;
        n_off   = r_off + OW'(1);
        if (w_off_last) begin
            n_off   = '0;
            n_plane = r_plane + 2'd1;
            if (r_plane == 2'd3) begin
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg.restart) begin
            r_pos     <= '0;
            r_plane   <= '0;
            r_off     <= '0;
            r_partial <= '0;
            for (int k = 0; k < MAX_STRIDE; k++) begin
                r_recent[k] <= '0;
            end
        end else if (w_acc) begin
            r_pos     <= n_pos;
            r_plane   <= n_plane;
            r_off     <= n_off;
            r_partial <= n_partial;
            if (w_pred) begin
                for (int k = MAX_STRIDE - 1; k > 0; k--) begin
                    r_recent[k] <= r_recent[k-1];
                end
                r_recent[0] <= w_r;
            end
        end
    end

    // Byte-plane store: lane p holds plane p, plane 0 being the most significant.
    frpd_ram #(
        .WIDTH (SW_STORE),
        .DEPTH (MAX_ROW_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_acc ? w_we : '0),
        .i_waddr (r_off),
        .i_wdata ({w_r, w_r, w_r}),
        .i_re    (w_re),
        .i_raddr (r_off),
        .o_rdata (w_rdata)
    );

    // Middle stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_acc && w_emit) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Middle stage payload.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit) begin
            r_s1_pred  <= w_pred;
            r_s1_word  <= w_word;
            r_s1_index <= w_index;
            r_s1_last  <= (r_plane == 2'd3) && w_off_last;
        end
    end

    // Merge the three stored planes with the final byte.
    assign w_s1_out = r_s1_pred
        ? {w_rdata[7:0], w_rdata[15:8], w_rdata[23:16], r_s1_word[7:0]}
        : r_s1_word;

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_o_word  <= w_s1_out;
            r_o_index <= r_s1_index;
            r_o_last  <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {2'b00, r_o_index, r_o_word};
    assign m_axis_tlast  = r_o_last;

endmodule
